// File: rtl/binary_image_icm_denoise_top_defines.svh
// Assertion macros for the binary image ICM denoiser.
// Used by bicm_seq and binary_image_icm_denoise_top; expects clk_i and rst_ni in scope.
`ifndef BINARY_IMAGE_ICM_DENOISE_TOP_DEFINES_SVH
`define BINARY_IMAGE_ICM_DENOISE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BICM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BICM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BICM_ASSERT(lbl, prop, msg)
`define BICM_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/bicm_pkg.sv
// Package for the binary image ICM denoiser: sizes, codes, control word and microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package bicm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = 9;
  localparam int WEIGHT_W   = 8;
  localparam int COUNT_W    = 17;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SUM_W      = 5;
  localparam int SCORE_W    = 10;
  localparam int STEP_W     = 5;

  localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(256);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(32);
  localparam logic [COUNT_W-1:0]  LIMIT_RST  = COUNT_W'(100000);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WEIGHT = 2'd2,
    CFG_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_RD,
    MEM_WR_PIN,
    MEM_WR_NXT
  } mem_op_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_ACCEPT,
    DP_CLR,
    DP_CUR,
    DP_ADD,
    DP_DECIDE,
    DP_WROUT,
    DP_RDOUT
  } dp_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN,
    COND_INVALID,
    COND_WRITE,
    COND_READ,
    COND_OUT_FREE
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 5'd0;
  localparam step_t STEP_CHECK  = 5'd1;
  localparam step_t STEP_ISWR   = 5'd2;
  localparam step_t STEP_ISRD   = 5'd3;
  localparam step_t STEP_CTR    = 5'd4;
  localparam step_t STEP_NB0    = 5'd5;
  localparam step_t STEP_NB1    = 5'd6;
  localparam step_t STEP_NB2    = 5'd7;
  localparam step_t STEP_NB3    = 5'd8;
  localparam step_t STEP_NB4    = 5'd9;
  localparam step_t STEP_NB5    = 5'd10;
  localparam step_t STEP_NB6    = 5'd11;
  localparam step_t STEP_NB7    = 5'd12;
  localparam step_t STEP_SUM    = 5'd13;
  localparam step_t STEP_DECIDE = 5'd14;
  localparam step_t STEP_EMIT   = 5'd15;
  localparam step_t STEP_WRITE  = 5'd16;
  localparam step_t STEP_READ   = 5'd17;
  localparam step_t STEP_RDOUT  = 5'd18;
  localparam step_t STEP_LAST   = STEP_RDOUT;

  typedef struct packed {
    mem_op_e            mem;
    logic signed [1:0]  dr;
    logic signed [1:0]  dc;
    dp_op_e             dp;
    cond_e              cond;
    logic               hold;
    step_t              target;
  } uop_t;

  typedef struct packed {
    logic in_valid;
    logic invalid;
    logic is_write;
    logic is_read;
    logic out_free;
  } stat_t;

  function automatic uop_t mk_uop(mem_op_e mem, logic signed [1:0] dr, logic signed [1:0] dc,
                                  dp_op_e dp, cond_e cond, logic hold, step_t target);
    uop_t u;
    u.mem    = mem;
    u.dr     = dr;
    u.dc     = dc;
    u.dp     = dp;
    u.cond   = cond;
    u.hold   = hold;
    u.target = target;
    return u;
  endfunction

  function automatic uop_t bicm_ucode(step_t s);
    uop_t u;
    unique case (s)
      STEP_IDLE:   u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_ACCEPT, COND_IN, 1'b1, STEP_CHECK);
      STEP_CHECK:  u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_NONE, COND_INVALID, 1'b0, STEP_EMIT);
      STEP_ISWR:   u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_NONE, COND_WRITE, 1'b0, STEP_WRITE);
      STEP_ISRD:   u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_NONE, COND_READ, 1'b0, STEP_READ);
      STEP_CTR:    u = mk_uop(MEM_RD, 2'sd0, 2'sd0, DP_CLR, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB0:    u = mk_uop(MEM_RD, -2'sd1, -2'sd1, DP_CUR, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB1:    u = mk_uop(MEM_RD, -2'sd1, 2'sd0, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB2:    u = mk_uop(MEM_RD, -2'sd1, 2'sd1, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB3:    u = mk_uop(MEM_RD, 2'sd0, -2'sd1, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB4:    u = mk_uop(MEM_RD, 2'sd0, 2'sd1, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB5:    u = mk_uop(MEM_RD, 2'sd1, -2'sd1, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB6:    u = mk_uop(MEM_RD, 2'sd1, 2'sd0, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_NB7:    u = mk_uop(MEM_RD, 2'sd1, 2'sd1, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_SUM:    u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_ADD, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_DECIDE: u = mk_uop(MEM_WR_NXT, 2'sd0, 2'sd0, DP_DECIDE, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_EMIT:   u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_NONE, COND_OUT_FREE, 1'b1, STEP_IDLE);
      STEP_WRITE:  u = mk_uop(MEM_WR_PIN, 2'sd0, 2'sd0, DP_WROUT, COND_ALWAYS, 1'b0, STEP_EMIT);
      STEP_READ:   u = mk_uop(MEM_RD, 2'sd0, 2'sd0, DP_NONE, COND_NEVER, 1'b0, STEP_IDLE);
      STEP_RDOUT:  u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_RDOUT, COND_ALWAYS, 1'b0, STEP_EMIT);
      default:     u = mk_uop(MEM_IDLE, 2'sd0, 2'sd0, DP_NONE, COND_ALWAYS, 1'b0, STEP_IDLE);
    endcase
    return u;
  endfunction

endpackage

// File: rtl/bicm_if.sv
// Valid/ready channel interfaces: command words in, result words out, register writes.
// Depends on bicm_pkg for field widths.
`timescale 1ns / 1ps

interface bicm_in_if import bicm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             pixel_in;

  modport src (output valid, command, row, col, pixel_in, input ready);
  modport snk (input valid, command, row, col, pixel_in, output ready);
endinterface

interface bicm_out_if import bicm_pkg::*;;
  logic               valid;
  logic               ready;
  logic               pixel_out;
  logic               changed;
  logic [COUNT_W-1:0] stable_count;
  logic               converged;

  modport src (output valid, pixel_out, changed, stable_count, converged, input ready);
  modport snk (input valid, pixel_out, changed, stable_count, converged, output ready);
endinterface

interface bicm_cfg_if import bicm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport src (output valid, index, data, input ready);
  modport snk (input valid, index, data, output ready);
endinterface

// File: rtl/bicm_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on bicm_pkg (control word, status struct, ROM function).
`timescale 1ns / 1ps
`include "binary_image_icm_denoise_top_defines.svh"

module bicm_seq import bicm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output uop_t  uop_o
);

  step_t step_q, step_d;
  uop_t  uop;
  logic  take;

  assign uop   = bicm_ucode(step_q);
  assign uop_o = uop;

  always_comb begin
    unique case (uop.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_IN:       take = stat_i.in_valid;
      COND_INVALID:  take = stat_i.invalid;
      COND_WRITE:    take = stat_i.is_write;
      COND_READ:     take = stat_i.is_read;
      COND_OUT_FREE: take = stat_i.out_free;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    priority if (take) begin
      step_d = uop.target;
    end else if (uop.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  `BICM_ASSERT_NEVER(a_step_range, step_q > STEP_LAST, "step counter outside program")

endmodule

// File: rtl/binary_image_icm_denoise_top.sv
// Binary image ICM denoiser top: pixel memory, datapath, registers and result register.
// Depends on bicm_pkg, bicm_if and bicm_seq.
// Each update runs the program in order: decode, nine reads, sum, write-back. Commands are taken
// one at a time: the next is accepted only after the result word of the last is loaded, and
// a result word not yet taken holds the sequencer in its emit step.
// Reset clears sequencer, counter, registers and output valid; pixel memory is not cleared.
`timescale 1ns / 1ps
`include "binary_image_icm_denoise_top_defines.svh"

module binary_image_icm_denoise_top import bicm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  bicm_in_if.snk         in_i,
  bicm_out_if.src        out_o,
  bicm_cfg_if.snk        cfg_i
);

  logic [DIM_W-1:0]    width_q, height_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [COUNT_W-1:0]  limit_q;
  logic [DIM_W-1:0]    w_eff, h_eff;

  cmd_e             cmd_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             pin_q;

  logic                    cur_q, rd_q, nbok_q, pout_q, chg_q;
  logic signed [SUM_W-1:0] acc_q;
  logic [COUNT_W-1:0]      count_q;

  logic               out_valid_q;
  logic               out_pix_q, out_chg_q, out_conv_q;
  logic [COUNT_W-1:0] out_count_q;

  logic mem [0:MEM_DEPTH-1];

  uop_t  uop;
  stat_t stat;
  logic  in_acc, out_free, out_load, nbok, nxt, mem_we, mem_wdata;
  logic signed [ROW_W+1:0] nr;
  logic signed [COL_W+1:0] nc;
  logic [ADDR_W-1:0]       addr;
  logic signed [SCORE_W-1:0] wx, score;

  always_comb begin
    priority if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    priority if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign in_i.ready  = (uop.dp == DP_ACCEPT);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_load    = (uop.cond == COND_OUT_FREE) && out_free;

  assign stat.in_valid = in_i.valid;
  assign stat.invalid  = (cmd_q == CMD_NOP) || ({1'b0, row_q} >= h_eff)
                         || ({1'b0, col_q} >= w_eff);
  assign stat.is_write = (cmd_q == CMD_WRITE);
  assign stat.is_read  = (cmd_q == CMD_READ);
  assign stat.out_free = out_free;

  bicm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uop_o  (uop)
  );

  assign nr   = $signed({2'b00, row_q}) + (ROW_W+2)'(uop.dr);
  assign nc   = $signed({2'b00, col_q}) + (COL_W+2)'(uop.dc);
  assign nbok = !nr[ROW_W+1] && !nc[COL_W+1] && (nr[ROW_W:0] < h_eff) && (nc[COL_W:0] < w_eff);
  assign addr = {nr[ROW_W-1:0], nc[COL_W-1:0]};

  assign wx    = SCORE_W'($signed(weight_q));
  assign score = $signed({acc_q, 4'b0000}) + (cur_q ? wx : -wx);
  assign nxt   = !score[SCORE_W-1];

  assign mem_we    = (uop.mem == MEM_WR_PIN) || (uop.mem == MEM_WR_NXT);
  assign mem_wdata = (uop.mem == MEM_WR_PIN) ? pin_q : nxt;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    if (uop.mem == MEM_RD) begin
      rd_q   <= mem[addr];
      nbok_q <= nbok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_e'(in_i.command);
      row_q <= in_i.row;
      col_q <= in_i.col;
      pin_q <= in_i.pixel_in;
    end
    if (uop.dp == DP_CUR) begin
      cur_q <= rd_q;
    end
    if (uop.dp == DP_CLR) begin
      acc_q <= '0;
    end else if (uop.dp == DP_ADD && nbok_q) begin
      acc_q <= rd_q ? acc_q + SUM_W'(1) : acc_q - SUM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pout_q  <= 1'b0;
      chg_q   <= 1'b0;
      count_q <= '0;
    end else begin
      unique case (uop.dp)
        DP_ACCEPT: begin
          if (in_i.valid) begin
            pout_q <= 1'b0;
            chg_q  <= 1'b0;
          end
        end
        DP_DECIDE: begin
          pout_q <= nxt;
          chg_q  <= (nxt != cur_q);
          if (nxt != cur_q) begin
            count_q <= '0;
          end else if (count_q != '1) begin
            count_q <= count_q + 1'b1;
          end
        end
        DP_WROUT: pout_q <= pin_q;
        DP_RDOUT: pout_q <= rd_q;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      weight_q <= WEIGHT_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        CFG_WEIGHT: weight_q <= cfg_i.data[WEIGHT_W-1:0];
        CFG_LIMIT:  limit_q  <= cfg_i.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q   <= pout_q;
      out_chg_q   <= chg_q;
      out_count_q <= count_q;
      out_conv_q  <= (count_q > limit_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_out    = out_pix_q;
  assign out_o.changed      = out_chg_q;
  assign out_o.stable_count = out_count_q;
  assign out_o.converged    = out_conv_q;

  `BICM_ASSERT(a_chg_clears_count, out_o.valid && out_o.changed |-> out_o.stable_count == '0, "changed word with nonzero count")
  `BICM_ASSERT(a_count_only_on_decide, count_q != $past(count_q) |-> $past(uop.dp == DP_DECIDE), "counter moved outside update")
  `BICM_ASSERT(a_accept_leaves_idle, in_acc |=> uop.dp != DP_ACCEPT, "sequencer stayed idle after accept")

endmodule
